### hw/rtl/gps_pkg.sv
// Shared types, constants and color conversion functions for the span shader.
package gps_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int LIGHT_LEVELS = 16;
   localparam int MAX_COLUMNS  = 2048;

   localparam int LIGHT_SHIFT = (LIGHT_LEVELS >= 32) ? 3 : 4;
   localparam int RED_SHIFT   = LIGHT_SHIFT + 7;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int LEFT_W      = COL_W + 1;
   localparam int LVL_W       = $clog2(LIGHT_LEVELS);
   localparam int SH_W        = 32 - RED_SHIFT;
   localparam int CEN_W       = FRAC_BITS + LVL_W + 1;
   localparam int LB_W        = ((SH_W > CEN_W) ? SH_W : CEN_W) + 1;
   localparam int MAG_W       = LB_W + 1;
   localparam int CNT_W       = $clog2(MAG_W + 1);
   localparam int OFF_W       = LVL_W + LIGHT_SHIFT + 1;
   localparam int SUM_W       = OFF_W + 2;

   localparam logic [LB_W-1:0] CENTRE = LB_W'((LIGHT_LEVELS / 2) << FRAC_BITS);

   // Reciprocals in 16-bit fixed point; exact for 8-bit dividends.
   localparam logic [11:0] RECIP_23 = 12'd2850;
   localparam logic [11:0] RECIP_25 = 12'd2622;
   localparam logic [11:0] RECIP_51 = 12'd1286;

   localparam logic OP_SPAN  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        base_colour;
      logic [COL_W-1:0]  start_x;
      logic [COL_W-1:0]  end_x;
      logic signed [31:0] light_begin;
      logic signed [31:0] light_final;
      logic              blend_mode;
      logic [7:0]        background;
   } req_type;

   typedef struct packed {
      logic [7:0]       pixel_value;
      logic [COL_W-1:0] pixel_x;
      logic             last_pixel;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIV_FIX,
      ST_SHADE
   } state_type;

   typedef struct packed {
      logic load_span;
      logic load_pixel;
      logic div_step;
      logic div_fix;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic span_empty;
      logic left_zero;
      logic div_last;
      logic out_busy;
   } status_type;

   typedef logic [23:0] rgb_tab_type [256];

   function automatic rgb_tab_type build_pal_tab();
      rgb_tab_type t;
      int v, rr, gg, r, g, b;
      for (int c = 0; c < 256; c++) begin
         if (c < 215) begin
            v  = 215 - c;
            rr = v / 36;
            v  = v - rr * 36;
            gg = v / 6;
            v  = v - gg * 6;
            r  = rr * 51;
            g  = gg * 51;
            b  = v * 51;
         end else if (c < 225) begin
            r = (255 * (225 - c)) / 10;
            g = 0;
            b = 0;
         end else if (c < 235) begin
            r = 0;
            g = (255 * (235 - c)) / 10;
            b = 0;
         end else if (c < 245) begin
            r = 0;
            g = 0;
            b = (255 * (245 - c)) / 10;
         end else begin
            r = (231 * (255 - c)) / 10;
            g = r;
            b = r;
         end
         t[c] = {8'(r), 8'(g), 8'(b)};
      end
      return t;
   endfunction

   localparam rgb_tab_type PAL_RGB = build_pal_tab();

   function automatic logic [7:0] recip_div(input logic [7:0] x, input logic [11:0] m);
      logic [19:0] prod;
      prod = 20'(x) * 20'(m);
      return 8'(prod[19:16]);
   endfunction

   function automatic logic [7:0] rgb_to_pal(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      logic [7:0] c;
      if (r == g && g == b) begin
         c = 8'd255 - recip_div(r, RECIP_23);
         if (c == 8'd244) c = 8'd0;
      end else if (r == 8'd0 && g == 8'd0) begin
         c = 8'd245 - recip_div(b, RECIP_25);
         if (c == 8'd245) c = 8'd255;
      end else if (r == 8'd0 && b == 8'd0) begin
         c = 8'd235 - recip_div(g, RECIP_25);
         if (c == 8'd235) c = 8'd255;
      end else if (b == 8'd0 && g == 8'd0) begin
         c = 8'd225 - recip_div(r, RECIP_25);
         if (c == 8'd225) c = 8'd255;
      end else begin
         c = 8'd215 - 8'(recip_div(r, RECIP_51) * 8'd36 + recip_div(g, RECIP_51) * 8'd6
                        + recip_div(b, RECIP_51));
         if (c == 8'd215) c = 8'd255;
      end
      return c;
   endfunction

   function automatic logic [7:0] clamp_add(input logic [7:0] c,
                                            input logic signed [OFF_W-1:0] off);
      logic signed [SUM_W-1:0] s;
      s = $signed(SUM_W'(c)) + SUM_W'(off);
      if (s < 0) return 8'd0;
      if (s > 255) return 8'd255;
      return 8'(s);
   endfunction

   // Screen blend of one channel: fg*(255-bg)/255 + bg.
   function automatic logic [7:0] blend_ch(input logic [7:0] fg, input logic [7:0] bg);
      logic [15:0] p;
      logic [16:0] q;
      p = 16'(fg) * 16'(8'd255 - bg);
      q = 17'(p) + 17'(p >> 8) + 17'd1;
      return q[15:8] + bg;
   endfunction

endpackage

### hw/rtl/gps_ctrl.sv
// Controller state machine for the span shader.
module gps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                opcode,
   input  gps_pkg::status_type status,
   output gps_pkg::cmd_type    cmd,
   output logic                req_stall
);
   import gps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (opcode == OP_SPAN) begin
                  cmd.load_span = 1'b1;
                  if (!status.span_empty) state_in = ST_DIVIDE;
               end else if (!status.left_zero) begin
                  cmd.load_pixel = 1'b1;
                  state_in       = ST_SHADE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SHADE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hw/rtl/gps_datapath.sv
// Datapath of the span shader: span state, step divider, shading and output register.
module gps_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gps_pkg::req_type    req_data,
   input  gps_pkg::cmd_type    cmd,
   output gps_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gps_pkg::rsp_type    rsp_data
);
   import gps_pkg::*;

   logic [31:0]       accum_ff, accum_in;
   logic [31:0]       step_ff, step_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [COL_W-1:0]  x_ff, x_in;
   logic [7:0]        colour_ff, colour_in;
   logic              blend_ff, blend_in;
   logic [7:0]        lit_ff, lit_in;
   logic [7:0]        bg_ff, bg_in;
   logic [COL_W-1:0]  px_x_ff, px_x_in;
   logic              last_ff, last_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [LEFT_W-1:0] rem_ff, rem_in;
   logic [LEFT_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic signed [SH_W-1:0]  sh_b, sh_f;
   logic signed [LB_W-1:0]  lb, lf;
   logic signed [MAG_W-1:0] diff;
   logic [MAG_W-1:0]        mag;
   logic [LEFT_W-1:0]       width;
   logic [LEFT_W:0]         rem_sh;
   logic                    ge;
   logic signed [MAG_W:0]   q_s;
   logic signed [31-FRAC_BITS:0] lvl_hi;
   logic [LVL_W-1:0]        level;
   logic signed [OFF_W-1:0] off;
   logic [23:0]             base_rgb, fg_rgb, bg_rgb;
   logic [7:0]              lit_idx, shade;

   // Span setup.
   assign sh_b  = $signed(req_data.light_begin[31:RED_SHIFT]);
   assign sh_f  = $signed(req_data.light_final[31:RED_SHIFT]);
   assign lb    = LB_W'(sh_b) + $signed(CENTRE);
   assign lf    = LB_W'(sh_f) + $signed(CENTRE);
   assign diff  = MAG_W'(lf) - MAG_W'(lb);
   assign mag   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign width = {1'b0, req_data.end_x} - {1'b0, req_data.start_x} + LEFT_W'(1);

   // One restoring division step per cycle.
   assign rem_sh = {rem_ff, quo_ff[MAG_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign q_s    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   // Lit color of the current pixel, from span state only.
   assign lvl_hi = $signed(accum_ff[31:FRAC_BITS]);
   always_comb begin
      if (lvl_hi < 0) begin
         level = '0;
      end else if (lvl_hi > (LIGHT_LEVELS - 1)) begin
         level = LVL_W'(LIGHT_LEVELS - 1);
      end else begin
         level = LVL_W'(lvl_hi);
      end
   end
   assign off      = ($signed(OFF_W'(level)) - $signed(OFF_W'(LIGHT_LEVELS / 2))) <<< LIGHT_SHIFT;
   assign base_rgb = PAL_RGB[colour_ff];
   assign lit_idx  = rgb_to_pal(clamp_add(base_rgb[23:16], off),
                                clamp_add(base_rgb[15:8], off),
                                clamp_add(base_rgb[7:0], off));

   // Screen blend over the existing pixel, when the span's blend flag is set.
   assign fg_rgb = PAL_RGB[lit_ff];
   assign bg_rgb = PAL_RGB[bg_ff];
   assign shade  = blend_ff ? rgb_to_pal(blend_ch(fg_rgb[23:16], bg_rgb[23:16]),
                                         blend_ch(fg_rgb[15:8], bg_rgb[15:8]),
                                         blend_ch(fg_rgb[7:0], bg_rgb[7:0]))
                            : lit_ff;

   always_comb begin
      accum_in     = accum_ff;
      step_in      = step_ff;
      left_in      = left_ff;
      x_in         = x_ff;
      colour_in    = colour_ff;
      blend_in     = blend_ff;
      lit_in       = lit_ff;
      bg_in        = bg_ff;
      px_x_in      = px_x_ff;
      last_in      = last_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load_span) begin
         colour_in = req_data.base_colour;
         blend_in  = req_data.blend_mode;
         x_in      = req_data.start_x;
         accum_in  = 32'(lb);
         step_in   = '0;
         left_in   = status.span_empty ? '0 : width;
         quo_in    = mag;
         rem_in    = '0;
         dvs_in    = width;
         neg_in    = diff[MAG_W-1];
         cnt_in    = CNT_W'(MAG_W);
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[MAG_W-2:0], ge};
         rem_in = ge ? LEFT_W'(rem_sh - {1'b0, dvs_ff}) : LEFT_W'(rem_sh);
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (cmd.div_fix) begin
         step_in = 32'(q_s);
      end
      if (cmd.load_pixel) begin
         lit_in   = lit_idx;
         bg_in    = req_data.background;
         px_x_in  = x_ff;
         last_in  = left_ff == LEFT_W'(1);
         accum_in = accum_ff + step_ff;
         x_in     = x_ff + COL_W'(1);
         left_in  = left_ff - LEFT_W'(1);
      end
      if (cmd.load_out) begin
         rsp_in.pixel_value = shade;
         rsp_in.pixel_x     = px_x_ff;
         rsp_in.last_pixel  = last_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         step_ff      <= '0;
         left_ff      <= '0;
         x_ff         <= '0;
         colour_ff    <= '0;
         blend_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         step_ff      <= step_in;
         left_ff      <= left_in;
         x_ff         <= x_in;
         colour_ff    <= colour_in;
         blend_ff     <= blend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff  <= lit_in;
      bg_ff   <= bg_in;
      px_x_ff <= px_x_in;
      last_ff <= last_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign status.span_empty = req_data.end_x < req_data.start_x;
   assign status.left_zero  = left_ff == '0;
   assign status.div_last   = cnt_ff == CNT_W'(1);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/gouraud_palette_span_shader.sv
// Top level of the Gouraud span shader for 8-bit palette images.
// A span-start transfer loads the base color, the inclusive column range, the two raw
// light values and the blend flag; it produces no result. For a non-empty span the
// block then computes the per-pixel light step in a bit-serial restoring divider and a
// final fix-up state, during which req_stall is high. A reversed span (end_x below
// start_x) is taken without a divide phase and shades nothing. Each pixel transfer
// carries the existing screen pixel and yields one result transfer with the shaded
// palette index, its column and a last-pixel flag: the lit color is computed from the
// span state and registered, then the optional screen blend is applied and the output
// register loaded. A new item is accepted while a result still waits in the output
// register; only a pixel whose result would overwrite an untaken one is held in the
// blend step. Pixel transfers arriving after the span is used up are taken
// and dropped. Light levels are saturated to the palette's range of light levels.
module gouraud_palette_span_shader (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gps_pkg::rsp_type rsp_data
);
   import gps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences span setup, division and pixel shading.
   gps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .opcode    (req_data.opcode),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // The datapath holds span state, the divider and the registered result.
   gps_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/gps_checker.sv
// Port-level assertions for the span shader and their binding to the top level.
module gps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input gps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gps_pkg::rsp_type rsp_data
);
   import gps_pkg::*;

   logic span_xfer;
   assign span_xfer = req_valid && !req_stall && req_data.opcode == OP_SPAN;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_span_divides: assert property (@(posedge clock) disable iff (reset)
      span_xfer && req_data.end_x >= req_data.start_x |=> req_stall)
      else $error("no divide phase after a non-empty span start");

   a_empty_span: assert property (@(posedge clock) disable iff (reset)
      span_xfer && req_data.end_x < req_data.start_x |=> !req_stall)
      else $error("empty span start did not return to idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind gouraud_palette_span_shader gps_checker u_checker (.*);

### sim/tb_gouraud_palette_span_shader.sv
// Self-checking testbench for the Gouraud palette span shader.
module tb_gouraud_palette_span_shader;
   import gps_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   gouraud_palette_span_shader uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Items waiting to be sent, with a flag that holds the sender back until
   // every pixel expected so far has come out.
   req_type pending_q[$];
   bit      drain_first_q[$];
   rsp_type pixel_expect_q[$];
   int      errors = 0;

   // Shadow copy of the span state.
   logic [31:0] sh_accum = '0;
   logic [31:0] sh_step  = '0;
   logic [11:0] sh_left  = '0;
   logic [10:0] sh_x     = '0;
   logic [7:0]  sh_colour = '0;
   logic        sh_blend  = 1'b0;

   task automatic palette_rgb(input int c, output int r, output int g, output int b);
      int v, rr, gg;
      if (c < 215) begin
         v  = 215 - c;
         rr = v / 36;
         v  = v - rr * 36;
         gg = v / 6;
         v  = v - gg * 6;
         r = rr * 51; g = gg * 51; b = v * 51;
      end else if (c < 225) begin
         r = (255 * (225 - c)) / 10; g = 0; b = 0;
      end else if (c < 235) begin
         r = 0; g = (255 * (235 - c)) / 10; b = 0;
      end else if (c < 245) begin
         r = 0; g = 0; b = (255 * (245 - c)) / 10;
      end else begin
         r = (231 * (255 - c)) / 10; g = r; b = r;
      end
   endtask

   function automatic int nearest_index(input int r, input int g, input int b);
      int c;
      if (r == g && g == b) begin
         c = 255 - r / 23;
         return (c == 244) ? 0 : c;
      end
      if (r == 0 && g == 0) begin
         c = 245 - b / 25;
         return (c == 245) ? 255 : c;
      end
      if (r == 0 && b == 0) begin
         c = 235 - g / 25;
         return (c == 235) ? 255 : c;
      end
      if (b == 0 && g == 0) begin
         c = 225 - r / 25;
         return (c == 225) ? 255 : c;
      end
      c = 215 - ((r / 51) * 36 + (g / 51) * 6 + b / 51);
      return (c == 215) ? 255 : c;
   endfunction

   function automatic int sat8(input int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
   endfunction

   // Updates the shadow state for one accepted item and, for a pixel inside the span, queues its expected pixel.
   task automatic shade_item(input req_type it);
      longint lb, lf, w;
      int lvl, off, r, g, b, br, bg, bb, val;
      rsp_type px;
      if (it.opcode == OP_SPAN) begin
         lb = longint'(it.light_begin >>> RED_SHIFT) + (longint'(LIGHT_LEVELS / 2) << FRAC_BITS);
         lf = longint'(it.light_final >>> RED_SHIFT) + (longint'(LIGHT_LEVELS / 2) << FRAC_BITS);
         w  = longint'(it.end_x) - longint'(it.start_x) + 1;
         sh_colour = it.base_colour;
         sh_blend  = it.blend_mode;
         sh_x      = it.start_x;
         sh_accum  = 32'(lb);
         if (w > 0) begin
            sh_left = 12'(w);
            sh_step = 32'((lf - lb) / w);
         end else begin
            sh_left = '0;
            sh_step = '0;
         end
      end else if (sh_left != 0) begin
         lvl = int'($signed(sh_accum) >>> FRAC_BITS);
         if (lvl < 0) lvl = 0;
         if (lvl > LIGHT_LEVELS - 1) lvl = LIGHT_LEVELS - 1;
         off = (lvl - LIGHT_LEVELS / 2) * (1 << LIGHT_SHIFT);
         palette_rgb(sh_colour, r, g, b);
         val = nearest_index(sat8(r + off), sat8(g + off), sat8(b + off));
         if (sh_blend) begin
            palette_rgb(it.background, br, bg, bb);
            palette_rgb(val, r, g, b);
            val = nearest_index(r * (255 - br) / 255 + br, g * (255 - bg) / 255 + bg,
                                b * (255 - bb) / 255 + bb);
         end
         px.pixel_value = 8'(val);
         px.pixel_x     = sh_x;
         px.last_pixel  = (sh_left == 1);
         pixel_expect_q.push_back(px);
         sh_accum = sh_accum + sh_step;
         sh_x     = sh_x + 1'b1;
         sh_left  = sh_left - 1'b1;
      end
   endtask

   function automatic req_type rand_item();
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, 8'($urandom)});
      return it;
   endfunction

   function automatic logic signed [31:0] rand_light();
      case ($urandom_range(0, 3))
         0: return $urandom;
         default: return $signed(32'($urandom_range(0, 32'h7FFF_FFFF))) - 32'sh4000_0000;
      endcase
   endfunction

   task automatic add_span(input int sx, input int ex, input logic signed [31:0] lb,
                           input logic signed [31:0] lf, input int colour, input bit blend,
                           input bit drain);
      req_type it;
      it = rand_item();
      it.opcode = OP_SPAN;
      it.start_x = 11'(sx);
      it.end_x = 11'(ex);
      it.light_begin = lb;
      it.light_final = lf;
      it.base_colour = 8'(colour);
      it.blend_mode = blend;
      pending_q.push_back(it);
      drain_first_q.push_back(drain);
   endtask

   task automatic add_pixels(input int n, input int bg);
      req_type it;
      for (int i = 0; i < n; i++) begin
         it = rand_item();
         it.opcode = OP_PIXEL;
         if (bg >= 0) it.background = 8'(bg);
         pending_q.push_back(it);
         drain_first_q.push_back(1'b0);
      end
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) shade_item(req_data);
         if (req_valid && req_stall) begin
            // Hold the stalled transfer as it is.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0 && !(drain_first_q[0] &&
                      (pixel_expect_q.size() != 0 || (req_valid && !req_stall)))) begin
            req_data  <= pending_q.pop_front();
            void'(drain_first_q.pop_front());
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: receiver stalls in phases, with one long hold-off.
   int cyc = 0;
   int stall_pct = 0;
   always @(posedge clock) begin
      cyc++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_expect_q.size() == 0) begin
            $display("%0t: unexpected pixel %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = pixel_expect_q.pop_front();
            if (rsp_data.pixel_value !== e.pixel_value) begin
               $display("%0t: pixel_value expected %0d actual %0d", $time,
                        e.pixel_value, rsp_data.pixel_value);
               errors++;
            end
            if (rsp_data.pixel_x !== e.pixel_x) begin
               $display("%0t: pixel_x expected %0d actual %0d", $time,
                        e.pixel_x, rsp_data.pixel_x);
               errors++;
            end
            if (rsp_data.last_pixel !== e.last_pixel) begin
               $display("%0t: last_pixel expected %0d actual %0d", $time,
                        e.last_pixel, rsp_data.last_pixel);
               errors++;
            end
         end
      end
      if (cyc % 97 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      if (cyc >= 1500 && cyc < 1800) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog on cycles without any transfer.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
         $display("tb_gouraud_palette_span_shader NOT OK");
         $finish;
      end
   end

   initial begin
      int sx, w, n;
      // Directed spans: extremes of light, columns and colours, blend on and off.
      add_span(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0, 1'b0);
      add_pixels(2, -1);                       // second pixel falls past the span end
      add_span(0, 3, 32'sh8000_0000, 32'sh7FFF_FFFF, 255, 1'b1, 1'b0);
      add_pixels(4, 0);
      add_span(2040, 2047, -32'sh4000_0000, 32'sh3FFF_FFFF, 215, 1'b1, 1'b0);
      add_pixels(8, 255);
      add_span(100, 50, 0, 0, 244, 1'b0, 1'b0); // reversed span gives no pixels
      add_pixels(2, -1);
      add_span(2047, 0, 0, 0, 12, 1'b1, 1'b0);
      add_pixels(1, -1);
      add_span(5, 6, 0, 32'sh0000_FFFF, 230, 1'b1, 1'b1);
      add_pixels(2, 250);
      // Random spans, mostly small, with a few very long ones.
      while (pending_q.size() < 545) begin
         sx = $urandom_range(0, 2047);
         w = ($urandom_range(0, 60) == 0) ? $urandom_range(200, 2048) : $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) w = -$urandom_range(0, 20);
         if (sx + w - 1 > 2047) w = 2048 - sx;
         if (sx + w - 1 < 0) w = 1 - sx;
         add_span(sx, sx + w - 1, rand_light(), rand_light(), $urandom_range(0, 255),
                  $urandom_range(0, 1), $urandom_range(0, 20) == 0);
         n = (w > 0) ? w : 0;
         case ($urandom_range(0, 5))
            0: n = n + $urandom_range(1, 2);
            1: n = n / 2;
            default: ;
         endcase
         // The pixels of a long span are cut short so the item count stays near its target.
         if (pending_q.size() + n > 555) n = 555 - pending_q.size();
         add_pixels(n, -1);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0 && !req_valid);
      wait (pixel_expect_q.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && pixel_expect_q.size() == 0) begin
         $display("tb_gouraud_palette_span_shader OK");
      end else begin
         $display("tb_gouraud_palette_span_shader NOT OK");
      end
      $finish;
   end

endmodule
